@@ rtl/ihex_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, constants and helpers of the HEX record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

	localparam int MAX_DATA_DEF = 16;

	localparam logic [7:0] TYPE_DATA  = 8'h00;
	localparam logic [7:0] TYPE_EOF   = 8'h01;
	localparam logic [7:0] TYPE_ELA   = 8'h04;
	localparam logic [7:0] START_MARK = 8'h3A;
	localparam logic [7:0] NEWLINE    = 8'h0A;
	localparam logic [6:0] POS_LIMIT  = 7'd127;
	localparam logic [9:0] HEADER_CHARS = 10'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PUSH,
		ST_EOF
	} state_t;

	typedef struct packed {
		logic take;      // character beat accepted
		logic rd_en;     // read record data at current index
		logic out_load;  // load data result into output register
		logic eof_load;  // load end-of-file result into output register
		logic k_inc;     // advance data index
	} cmd_t;

	typedef struct packed {
		logic end_data;  // newline closes a data record with bytes
		logic end_eof;   // newline closes an end-of-file record
		logic k_last;    // current index is the record's final byte
		logic out_free;  // output register can take a result
	} status_t;

	// {valid, value}; valid low for a non-hex character
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

endpackage

@@ rtl/ihex_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ihex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ihex_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_ctrl
// Controller: accepts characters, sequences the result run of a record.
// ----------------------------------------------------------------------------
module ihex_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ihex_pkg::status_t st,
	output ihex_pkg::cmd_t    cmd
);

	ihex_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ihex_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ihex_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && st.end_data)
					state_d = ihex_pkg::ST_READ;
				else if (in_valid && st.end_eof)
					state_d = ihex_pkg::ST_EOF;
			end
			ihex_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ihex_pkg::ST_PUSH;
			end
			ihex_pkg::ST_PUSH: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					if (st.k_last) begin
						state_d = ihex_pkg::ST_IDLE;
					end else begin
						cmd.k_inc = 1'b1;
						state_d   = ihex_pkg::ST_READ;
					end
				end
			end
			ihex_pkg::ST_EOF: begin
				if (st.out_free) begin
					cmd.eof_load = 1'b1;
					state_d      = ihex_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ihex_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/ihex_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_dpath
// Datapath: line parsing registers, record data store, result register.
// ----------------------------------------------------------------------------
module ihex_dpath #(
	parameter int MAX_DATA = ihex_pkg::MAX_DATA_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        char_byte,
	input  ihex_pkg::cmd_t    cmd,
	output ihex_pkg::status_t st,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       byte_address,
	output logic [7:0]        data_byte,
	output logic              last,
	output logic              end_of_file
);

	localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
	localparam logic [7:0] MAX_B = 8'(MAX_DATA);
	localparam logic ELA_OK = (MAX_DATA >= 2);

	logic [6:0]  pos_q;
	logic [3:0]  hold_q;
	logic [7:0]  len_q;
	logic [15:0] offset_q;
	logic [7:0]  type_q;
	logic [15:0] upper_q;
	logic        bad_q;
	logic        done_q;
	logic [7:0]  ela_hi_q;
	logic [7:0]  ela_lo_q;
	logic [7:0]  k_q;
	logic        out_valid_q;

	logic [4:0]  hex;
	logic [5:0]  pair;
	logic [5:0]  didx;
	logic [IDX_W-1:0] ram_waddr;
	logic [7:0]  v;
	logic        is_nl;
	logic        line_ok;
	logic        ela_upd;
	logic        char_act;
	logic        digit_act;
	logic        ram_we;
	logic [7:0]  ram_rdata;

	assign hex   = ihex_pkg::hex_value(char_byte);
	assign pair  = 6'((pos_q - 7'd1) >> 1);
	assign didx  = pair - 6'd4;
	assign ram_waddr = IDX_W'(didx);
	assign v     = {hold_q, hex[3:0]};
	assign is_nl = (char_byte == ihex_pkg::NEWLINE) && !done_q;

	assign line_ok = !bad_q &&
		({3'b000, pos_q} >= ihex_pkg::HEADER_CHARS + {1'b0, len_q, 1'b0});

	assign st.end_data = is_nl && line_ok && (type_q == ihex_pkg::TYPE_DATA) &&
		(len_q != 8'd0) && (len_q <= MAX_B);
	assign st.end_eof  = is_nl && line_ok && (type_q == ihex_pkg::TYPE_EOF);
	assign ela_upd     = is_nl && line_ok && (type_q == ihex_pkg::TYPE_ELA) &&
		(len_q >= 8'd2) && ELA_OK;
	assign st.k_last   = ({1'b0, k_q} + 9'd1) == {1'b0, len_q};
	assign st.out_free = !out_valid_q || out_ready;

	// a counted, not yet dropped, non-start character
	assign char_act  = cmd.take && !done_q && (char_byte != ihex_pkg::NEWLINE) &&
		(pos_q < ihex_pkg::POS_LIMIT) && !bad_q && (pos_q != 7'd0);
	assign digit_act = char_act && !(pair >= 6'd4 && {2'b00, didx} >= len_q);
	assign ram_we    = digit_act && hex[4] && !pos_q[0] && (pair >= 6'd4) &&
		({2'b00, didx} < MAX_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hold_q   <= '0;
			len_q    <= '0;
			offset_q <= '0;
			type_q   <= '0;
			upper_q  <= '0;
			bad_q    <= 1'b0;
			done_q   <= 1'b0;
		end else if (cmd.take && !done_q) begin
			if (char_byte == ihex_pkg::NEWLINE) begin
				pos_q <= '0;
				bad_q <= 1'b0;
				if (ela_upd)
					upper_q <= {ela_hi_q, ela_lo_q};
				if (st.end_eof)
					done_q <= 1'b1;
			end else if (pos_q < ihex_pkg::POS_LIMIT) begin
				pos_q <= pos_q + 7'd1;
				if (!bad_q && pos_q == 7'd0) begin
					if (char_byte != ihex_pkg::START_MARK)
						bad_q <= 1'b1;
				end else if (digit_act) begin
					if (!hex[4]) begin
						bad_q <= 1'b1;
					end else if (pos_q[0]) begin
						hold_q <= hex[3:0];
					end else begin
						case (pair)
							6'd0: begin
								len_q <= v;
								if (v > MAX_B)
									bad_q <= 1'b1;
							end
							6'd1: offset_q[15:8] <= v;
							6'd2: offset_q[7:0]  <= v;
							6'd3: type_q <= v;
							default: ;
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we && didx == 6'd0)
			ela_hi_q <= v;
		if (ram_we && didx == 6'd1)
			ela_lo_q <= v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			k_q <= '0;
		else if (cmd.take)
			k_q <= '0;
		else if (cmd.k_inc)
			k_q <= k_q + 8'd1;
	end

	ihex_ram #(
		.WIDTH(8),
		.DEPTH(MAX_DATA)
	) u_data_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(v),
		.re   (cmd.rd_en),
		.raddr(k_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load || cmd.eof_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			byte_address <= {upper_q, offset_q} + {24'd0, k_q};
			data_byte    <= ram_rdata;
			last         <= st.k_last;
			end_of_file  <= 1'b0;
		end else if (cmd.eof_load) begin
			byte_address <= '0;
			data_byte    <= '0;
			last         <= 1'b1;
			end_of_file  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/intel_hex_record_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_parser_unit
// HEX text parser: one character per beat in, one data byte per beat out.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid, in_ready, char_byte    | character beats in
//  out     | out_valid, out_ready,            | result beats out
//          | byte_address, data_byte,         |
//          | last, end_of_file                |
//
// A character is accepted whenever in_ready is high. A newline closing a
// data record holds in_ready low while each byte is read from the record
// data RAM and loaded into the output register, and while out_ready
// stalls a load. An end-of-file record's newline holds in_ready low until
// the result is loaded. Reset is asynchronous; the data RAM is not cleared.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_unit #(
	parameter int MAX_DATA = ihex_pkg::MAX_DATA_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] byte_address,
	output logic [7:0]  data_byte,
	output logic        last,
	output logic        end_of_file
);

	ihex_pkg::cmd_t    cmd;
	ihex_pkg::status_t st;

	ihex_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st      (st),
		.cmd     (cmd)
	);

	ihex_dpath #(
		.MAX_DATA(MAX_DATA)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_byte   (char_byte),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.byte_address(byte_address),
		.data_byte   (data_byte),
		.last        (last),
		.end_of_file (end_of_file)
	);

endmodule
